FILE: sv/fqnp_pkg.sv
package fqnp_pkg;

    // Queue geometry
    localparam int DEPTH   = 16;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int DATA_W  = 32;
    localparam int ENTRIES_W = 5;

    // Operation codes
    typedef enum logic [1:0] {
        MODE_ENQ   = 2'd0,
        MODE_DEQ   = 2'd1,
        MODE_PURGE = 2'd2
    } t_mode;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_DEQ,
        S_PURGE
    } t_state;

endpackage

FILE: sv/fifo_queue_with_negative_purge_unit.sv
// Queue of signed words in a one-port-write, one-port-read ring memory.
// Enqueue, no-op and any empty or full case: result in the cycle after start, busy stays low.
// Dequeue: the head is read into the registered read data, then the result is registered; busy high for one cycle.
// Purge: walks every entry, with at most one memory read and at most one write back per cycle.
// Synchronous active-low reset empties the queue; ring contents are left as they are.
// The receiver cannot stall: every result beat is shown for exactly one cycle.
module fifo_queue_with_negative_purge_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          i_mode,
    input  logic signed [fqnp_pkg::DATA_W-1:0]  i_value_in,
    output logic                                o_valid,
    output logic signed [fqnp_pkg::DATA_W-1:0]  o_value_out,
    output logic [1:0]                          o_status,
    output logic [fqnp_pkg::ENTRIES_W-1:0]      o_entries,
    output logic                                o_is_empty
);
    import fqnp_pkg::*;

    // Ring memory and registered read data
    logic signed [DATA_W-1:0] r_mem [DEPTH];
    logic signed [DATA_W-1:0] r_rd_data;

    // Control state
    t_state             r_state,   n_state;
    logic [ADDR_W-1:0]  r_head,    n_head;
    logic [ADDR_W-1:0]  r_tail,    n_tail;
    logic [CNT_W-1:0]   r_count,   n_count;
    logic [ADDR_W-1:0]  r_rd_ptr,  n_rd_ptr;
    logic [ADDR_W-1:0]  r_wr_ptr,  n_wr_ptr;
    logic [CNT_W-1:0]   r_issued,  n_issued;
    logic [CNT_W-1:0]   r_kept,    n_kept;

    // Result beat
    logic                     r_valid,  n_valid;
    logic signed [DATA_W-1:0] r_value,  n_value;
    t_status                  r_status, n_status;
    logic [ENTRIES_W-1:0]     r_entries, n_entries;
    logic                     r_empty,  n_empty;

    // Memory controls
    logic                     w_wr_en;
    logic [ADDR_W-1:0]        w_wr_addr;
    logic signed [DATA_W-1:0] w_wr_data;
    logic                     w_rd_en;
    logic [ADDR_W-1:0]        w_rd_addr;

    logic        w_accept;
    logic [CNT_W-1:0] w_kept_next;
    logic [ADDR_W-1:0] w_wr_next;

    function automatic logic [ADDR_W-1:0] wrap_inc(input logic [ADDR_W-1:0] idx);
        logic [ADDR_W-1:0] res;
        if (idx == ADDR_W'(DEPTH - 1)) begin
            res = '0;
        end else begin
            res = idx + 1'b1;
        end
        return res;
    endfunction

    assign w_accept = start && !busy;
    assign busy     = (r_state != S_IDLE);

    // Memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_tail   <= '0;
            r_count  <= '0;
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_issued <= '0;
            r_kept   <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_count  <= n_count;
            r_rd_ptr <= n_rd_ptr;
            r_wr_ptr <= n_wr_ptr;
            r_issued <= n_issued;
            r_kept   <= n_kept;
            r_valid  <= n_valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_value   <= n_value;
        r_status  <= n_status;
        r_entries <= n_entries;
        r_empty   <= n_empty;
    end

    // Next state, memory access and result
    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        n_rd_ptr  = r_rd_ptr;
        n_wr_ptr  = r_wr_ptr;
        n_issued  = r_issued;
        n_kept    = r_kept;
        n_valid   = 1'b0;
        n_value   = '0;
        n_status  = ST_OK;
        n_entries = ENTRIES_W'(r_count);
        n_empty   = (r_count == '0);
        w_wr_en   = 1'b0;
        w_wr_addr = r_tail;
        w_wr_data = i_value_in;
        w_rd_en   = 1'b0;
        w_rd_addr = r_head;
        w_kept_next = r_kept;
        w_wr_next   = r_wr_ptr;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (t_mode'(i_mode))
                        MODE_ENQ: begin
                            n_valid = 1'b1;
                            if (r_count == CNT_W'(DEPTH)) begin
                                n_status = ST_FULL;
                            end else begin
                                w_wr_en   = 1'b1;
                                n_tail    = wrap_inc(r_tail);
                                n_count   = r_count + 1'b1;
                                n_entries = ENTRIES_W'(r_count + 1'b1);
                                n_empty   = 1'b0;
                            end
                        end
                        MODE_DEQ: begin
                            if (r_count == '0) begin
                                n_valid  = 1'b1;
                                n_value  = '1;
                                n_status = ST_EMPTY;
                            end else begin
                                // read head into the read data register now; S_DEQ registers it as the result
                                w_rd_en = 1'b1;
                                n_head  = wrap_inc(r_head);
                                n_count = r_count - 1'b1;
                                n_state = S_DEQ;
                            end
                        end
                        MODE_PURGE: begin
                            if (r_count == '0) begin
                                n_valid = 1'b1;
                            end else begin
                                // first read of the walk
                                w_rd_en  = 1'b1;
                                n_rd_ptr = wrap_inc(r_head);
                                n_wr_ptr = r_head;
                                n_issued = CNT_W'(1);
                                n_kept   = '0;
                                n_state  = S_PURGE;
                            end
                        end
                        default: begin
                            n_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_DEQ: begin
                n_valid   = 1'b1;
                n_value   = r_rd_data;
                n_entries = ENTRIES_W'(r_count);
                n_empty   = (r_count == '0);
                n_state   = S_IDLE;
            end
            S_PURGE: begin
                // keep a non-negative entry by writing it back at the pack pointer;
                // the pack pointer never passes the read pointer, so no overlap
                if (!r_rd_data[DATA_W-1]) begin
                    w_wr_en     = 1'b1;
                    w_wr_addr   = r_wr_ptr;
                    w_wr_data   = r_rd_data;
                    w_wr_next   = wrap_inc(r_wr_ptr);
                    w_kept_next = r_kept + 1'b1;
                end
                n_wr_ptr = w_wr_next;
                n_kept   = w_kept_next;
                if (r_issued != r_count) begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = r_rd_ptr;
                    n_rd_ptr  = wrap_inc(r_rd_ptr);
                    n_issued  = r_issued + 1'b1;
                end else begin
                    // last beat of the walk
                    n_tail    = w_wr_next;
                    n_count   = w_kept_next;
                    n_valid   = 1'b1;
                    n_entries = ENTRIES_W'(w_kept_next);
                    n_empty   = (w_kept_next == '0);
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_valid     = r_valid;
    assign o_value_out = r_value;
    assign o_status    = r_status;
    assign o_entries   = r_entries;
    assign o_is_empty  = r_empty;

endmodule
